### hdl/pptsched_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pptsched_pkg;

  localparam int unsigned TASK_SLOTS = 8;
  localparam int unsigned SLOT_W     = $clog2(TASK_SLOTS);
  localparam int unsigned PRIO_W     = 8;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned MASK_W     = 8;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TASK_PRIORITIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTOSTART_MASK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT      = 2'd2;

  typedef enum logic [1:0] {
    MODE_INIT      = 2'd0,
    MODE_ACTIVATE  = 2'd1,
    MODE_TERMINATE = 2'd2,
    MODE_CHAIN     = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SLOT_W-1:0] task_id;
  } evt_t;

  typedef struct packed {
    logic              dispatch;
    logic [SLOT_W-1:0] run_task;
    logic              running_valid;
    logic              idle;
    logic              bad_task;
  } res_t;

endpackage

`default_nettype wire

### hdl/pptsched_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pptsched_evt_if;
  logic                valid;
  logic                ready;
  pptsched_pkg::evt_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pptsched_res_if;
  logic                valid;
  logic                ready;
  pptsched_pkg::res_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/preemptive_priority_task_scheduler_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake      Payload
// evt_i     in         valid/ready    mode, task_id
// res_o     out        valid/ready    dispatch, run_task, running_valid, idle, bad_task
// cfg       in         cfg_we_i       cfg_idx_i, cfg_data_i (write only)
//
// An event is handled in order: the accept cycle applies the table update, a single
// priority comparator then walks all slots one per cycle, and the decide state loads
// the result register. evt_i.ready is high only between events.
// A stalled result holds in its register; the next event may be accepted meanwhile,
// and its decide cycle waits until the held result is taken. Reset clears the task
// table, the configuration, the sequencer and the result valid.

module preemptive_priority_task_scheduler_top (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [pptsched_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [pptsched_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  pptsched_evt_if.sink                              evt_i,
  pptsched_res_if.source                            res_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  localparam int unsigned SW = pptsched_pkg::SLOT_W;
  localparam int unsigned PW = pptsched_pkg::PRIO_W;
  localparam int unsigned CW = pptsched_pkg::COUNT_W;
  localparam int unsigned NS = pptsched_pkg::TASK_SLOTS;

  localparam logic [SW-1:0] LAST_SLOT = SW'(NS - 1);
  localparam logic [CW-1:0] MAX_LIM   = CW'(NS);

  logic [1:0]                             fsm_q, fsm_d;
  logic [PW*NS-1:0]                       prio_q;
  logic [pptsched_pkg::MASK_W-1:0]        mask_q;
  logic [CW-1:0]                          count_q;
  logic [NS-1:0]                          ready_q, ready_d;
  logic [SW-1:0]                          cur_q, cur_d;
  logic                                   cur_valid_q, cur_valid_d;
  logic                                   bad_q, bad_d;
  logic [SW-1:0]                          idx_q, idx_d;
  logic [SW-1:0]                          best_q, best_d;
  logic [PW-1:0]                          maxp_q, maxp_d;
  logic                                   found_q, found_d;
  logic                                   more_q, more_d;
  pptsched_pkg::res_t                     res_q, res_d;
  logic                                   res_valid_q, res_valid_d;

  logic [CW-1:0]  lim;
  logic           evt_acc;
  logic           id_ok;
  logic [PW-1:0]  scan_prio;
  logic           qualify;
  logic [PW-1:0]  best_prio;
  logic [PW-1:0]  cur_prio;
  logic           cur_in_lim;
  logic           can_load;
  logic           disp;

  assign lim        = (count_q > MAX_LIM) ? MAX_LIM : count_q;
  assign evt_acc    = evt_i.valid && evt_i.ready;
  assign id_ok      = {1'b0, evt_i.data.task_id} < lim;
  assign scan_prio  = prio_q[PW*idx_q +: PW];
  assign best_prio  = prio_q[PW*best_q +: PW];
  assign cur_prio   = prio_q[PW*cur_q +: PW];
  assign cur_in_lim = {1'b0, cur_q} < lim;
  assign qualify    = ({1'b0, idx_q} < lim) && ready_q[idx_q] && (scan_prio != '0);
  assign can_load   = !res_valid_q || res_o.ready;
  assign disp       = found_q && !bad_q && (!cur_valid_q || (best_prio > cur_prio));

  assign evt_i.ready = (fsm_q == S_IDLE);
  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  always_comb begin
    fsm_d       = fsm_q;
    ready_d     = ready_q;
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    bad_d       = bad_q;
    idx_d       = idx_q;
    best_d      = best_q;
    maxp_d      = maxp_q;
    found_d     = found_q;
    more_d      = more_q;
    res_d       = res_q;
    res_valid_d = res_valid_q;

    if (res_valid_q && res_o.ready) begin
      res_valid_d = 1'b0;
    end

    unique case (fsm_q)
      S_IDLE: begin
        if (evt_acc) begin
          bad_d   = 1'b0;
          idx_d   = '0;
          best_d  = '0;
          maxp_d  = '0;
          found_d = 1'b0;
          more_d  = 1'b0;
          fsm_d   = S_SCAN;
          case (evt_i.data.mode)
            pptsched_pkg::MODE_INIT: begin
              for (int i = 0; i < NS; i++) begin
                ready_d[i] = (CW'(i) < lim) && mask_q[i];
              end
              cur_d       = '0;
              cur_valid_d = 1'b0;
            end
            pptsched_pkg::MODE_ACTIVATE: begin
              if (!id_ok) begin
                bad_d = 1'b1;
              end else if (!(cur_valid_q && (cur_q == evt_i.data.task_id))) begin
                ready_d[evt_i.data.task_id] = 1'b1;
              end
            end
            pptsched_pkg::MODE_TERMINATE: begin
              if (!cur_valid_q) begin
                bad_d = 1'b1;
              end else begin
                cur_d       = '0;
                cur_valid_d = 1'b0;
              end
            end
            default: begin
              if (!id_ok) begin
                bad_d = 1'b1;
              end else begin
                cur_d                       = '0;
                cur_valid_d                 = 1'b0;
                ready_d[evt_i.data.task_id] = 1'b1;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        if (qualify) begin
          found_d = 1'b1;
          if (found_q) begin
            more_d = 1'b1;
          end
          if (scan_prio > maxp_q) begin
            maxp_d = scan_prio;
            best_d = idx_q;
          end
        end
        if (idx_q == LAST_SLOT) begin
          fsm_d = S_DECIDE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DECIDE: begin
        if (can_load) begin
          res_valid_d       = 1'b1;
          res_d.dispatch    = disp;
          res_d.bad_task    = bad_q;
          if (disp) begin
            if (cur_valid_q) begin
              ready_d[cur_q] = 1'b1;
            end
            ready_d[best_q]     = 1'b0;
            cur_d               = best_q;
            cur_valid_d         = 1'b1;
            res_d.run_task      = best_q;
            res_d.running_valid = 1'b1;
            res_d.idle = !(more_q || (cur_valid_q && cur_in_lim && (cur_prio != '0)));
          end else begin
            res_d.run_task      = cur_valid_q ? cur_q : '0;
            res_d.running_valid = cur_valid_q;
            res_d.idle          = !found_q;
          end
          fsm_d = S_IDLE;
        end
      end
      default: begin
        fsm_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= S_IDLE;
      prio_q      <= '0;
      mask_q      <= '0;
      count_q     <= '0;
      ready_q     <= '0;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      ready_q     <= ready_d;
      cur_q       <= cur_d;
      cur_valid_q <= cur_valid_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pptsched_pkg::CFG_TASK_PRIORITIES: prio_q  <= cfg_data_i[PW*NS-1:0];
          pptsched_pkg::CFG_AUTOSTART_MASK:  mask_q  <= cfg_data_i[pptsched_pkg::MASK_W-1:0];
          pptsched_pkg::CFG_TASK_COUNT:      count_q <= cfg_data_i[CW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bad_q   <= bad_d;
    idx_q   <= idx_d;
    best_q  <= best_d;
    maxp_q  <= maxp_d;
    found_q <= found_d;
    more_q  <= more_d;
    res_q   <= res_d;
  end

`ifndef SYNTH
  a_run_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> !ready_q[cur_q])
    else $error("running task also marked ready");

  a_result_from_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(fsm_q == S_DECIDE))
    else $error("result loaded outside decide cycle");

  a_dispatch_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.data.dispatch) |-> (res_o.data.running_valid && !res_o.data.bad_task))
    else $error("dispatch without running task or on rejected event");

  a_nothing_running_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cur_valid_q |-> (cur_q == '0))
    else $error("idle slot index not cleared");
`endif

endmodule

`default_nettype wire
